// ===== src/mme_pkg.sv =====
// Shared constants, types and codes of the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int RES_W   = PROD_W + IDX_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_e;

endpackage

// ===== src/mme_in_if.sv =====
// Input channel: load and compute beats.
`timescale 1ns / 1ps

interface mme_in_if;
  import mme_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [ADDR_W-1:0]            elem_index;
  logic signed [ELEM_WIDTH-1:0] element_value;

  modport source (output valid, output opcode, output elem_index, output element_value,
                  input ready);
  modport sink   (input valid, input opcode, input elem_index, input element_value,
                  output ready);
endinterface

// ===== src/mme_out_if.sv =====
// Output channel: result element beats.
`timescale 1ns / 1ps

interface mme_out_if;
  import mme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic                    is_last;

  modport source (output valid, output result_value, output out_row, output out_col,
                  output is_last, input ready);
  modport sink   (input valid, input result_value, input out_row, input out_col,
                  input is_last, output ready);
endinterface

// ===== src/matrix_multiply_engine.sv =====
// Top level of the fixed-point matrix multiply engine.
`timescale 1ns / 1ps

// Loads one Q8.8 element of A or B per beat while idle (out-of-range
// indices dropped) and, on a compute beat, streams every element of
// C = A x B in row-major order as an exact Q19.16 dot product, is_last on the
// final one. A single multiplier and accumulator are shared by all products:
// each multiply-accumulate steps through store read, multiply and add, and
// each result element through an emit step that stalls while the previous
// result is still waiting on the output. The input is not ready during a
// compute; a waiting result does not block loads.
// Store entries never loaded read as unknown values.
module matrix_multiply_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mme_pkg::DIM_W-1:0]       cfg_data_i,
  mme_in_if.sink                          in_i,
  mme_out_if.source                       out_o
);
  import mme_pkg::*;

  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

  state_e state_q, state_d;

  logic [DIM_W-1:0]  rows_q, inner_q, cols_q;
  logic [DIM_W-1:0]  nr, nk, nc;
  logic [AREA_W-1:0] area_a, area_b;

  logic [IDX_W-1:0]  r_q, r_d, c_q, c_d, k_q, k_d;
  logic [ADDR_W:0]   row_base_q, row_base_d, b_addr_q, b_addr_d, a_addr;
  logic [RES_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic                   out_valid_q, out_valid_d;
  logic [RES_W-1:0]       res_q, res_d;
  logic [IDX_W-1:0]       row_q, row_d, col_q, col_d;
  logic                   last_q, last_d;

  logic a_we, b_we, last_elem, last_col;
  logic [ELEM_WIDTH-1:0] a_rd, b_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= MaxDim;
      inner_q <= MaxDim;
      cols_q  <= MaxDim;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_ROWS:  rows_q  <= cfg_data_i;
        CFG_INNER: inner_q <= cfg_data_i;
        CFG_COLS:  cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr = (rows_q  > MaxDim) ? MaxDim : rows_q;
  assign nk = (inner_q > MaxDim) ? MaxDim : inner_q;
  assign nc = (cols_q  > MaxDim) ? MaxDim : cols_q;

  assign area_a = AREA_W'(nr) * AREA_W'(nk);
  assign area_b = AREA_W'(nk) * AREA_W'(nc);

  assign a_addr    = row_base_q + (ADDR_W + 1)'(k_q);
  assign last_col  = ({1'b0, c_q} == nc - DIM_W'(1));
  assign last_elem = last_col && ({1'b0, r_q} == nr - DIM_W'(1));

  mme_ram #(.Width(ELEM_WIDTH), .Depth(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (in_i.elem_index),
    .wdata_i (in_i.element_value),
    .raddr_i (a_addr[ADDR_W-1:0]),
    .rdata_o (a_rd)
  );

  mme_ram #(.Width(ELEM_WIDTH), .Depth(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (in_i.elem_index),
    .wdata_i (in_i.element_value),
    .raddr_i (b_addr_q[ADDR_W-1:0]),
    .rdata_o (b_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      row_base_q  <= '0;
      b_addr_q    <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      row_base_q  <= row_base_d;
      b_addr_q    <= b_addr_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
    row_q  <= row_d;
    col_q  <= col_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    row_base_d  = row_base_q;
    b_addr_d    = b_addr_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    res_d       = res_q;
    row_d       = row_q;
    col_d       = col_q;
    last_d      = last_q;
    a_we        = 1'b0;
    b_we        = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (opcode_e'(in_i.opcode))
            OP_LOAD_A: a_we = (AREA_W'(in_i.elem_index) < area_a);
            OP_LOAD_B: b_we = (AREA_W'(in_i.elem_index) < area_b);
            OP_COMPUTE: begin
              if (nr != '0 && nc != '0) begin
                r_d        = '0;
                c_d        = '0;
                k_d        = '0;
                row_base_d = '0;
                b_addr_d   = '0;
                acc_d      = '0;
                state_d    = (nk == '0) ? ST_EMIT : ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_d = ST_MUL;
      ST_MUL: begin
        prod_d  = $signed(a_rd) * $signed(b_rd);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d    = acc_q + {{(RES_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
        k_d      = k_q + IDX_W'(1);
        b_addr_d = b_addr_q + (ADDR_W + 1)'(nc);
        state_d  = ({1'b0, k_q} == nk - DIM_W'(1)) ? ST_EMIT : ST_FETCH;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          res_d       = acc_q;
          row_d       = r_q;
          col_d       = c_q;
          last_d      = last_elem;
          k_d         = '0;
          acc_d       = '0;
          if (last_elem) begin
            state_d = ST_IDLE;
          end else begin
            if (last_col) begin
              c_d        = '0;
              r_d        = r_q + IDX_W'(1);
              row_base_d = row_base_q + (ADDR_W + 1)'(nk);
              b_addr_d   = '0;
            end else begin
              c_d      = c_q + IDX_W'(1);
              b_addr_d = (ADDR_W + 1)'(c_q) + (ADDR_W + 1)'(1);
            end
            state_d = (nk == '0) ? ST_EMIT : ST_FETCH;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = res_q;
  assign out_o.out_row      = row_q;
  assign out_o.out_col      = col_q;
  assign out_o.is_last      = last_q;

  a_fetch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> (a_addr < (ADDR_W + 1)'(DEPTH)) &&
                            (b_addr_q < (ADDR_W + 1)'(DEPTH)))
    else $error("store read address out of range");

  a_k_below_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_ACC) |-> ({1'b0, k_q} < nk))
    else $error("inner counter past inner dimension");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.opcode == OP_COMPUTE && nr != '0 && nc != '0)
      |=> !in_i.ready)
    else $error("input ready right after a compute beat");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result beat raised outside emit");

endmodule

// ===== src/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mme_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/matrix_multiply_engine_tb.sv =====
// Testbench for the matrix multiply engine: checks every result beat against a local predictor.
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 700;
  localparam int unsigned LIMIT_CYCLES  = 2000000;

  typedef struct packed {
    logic [1:0]                   op;
    logic [ADDR_W-1:0]            idx;
    logic signed [ELEM_WIDTH-1:0] val;
  } beat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } product_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();

  matrix_multiply_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Predictor state
  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic [DIM_W-1:0]             dim_rows = 4'd8;
  logic [DIM_W-1:0]             dim_inner = 4'd8;
  logic [DIM_W-1:0]             dim_cols = 4'd8;

  product_t    expected_products [$];
  beat_t       pending_beats [$];
  bit          gen_a_ok [DEPTH];
  bit          gen_b_ok [DEPTH];
  int unsigned beats_queued = 0;
  int unsigned beats_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen;
  int unsigned hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clip_dim(logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : d;
  endfunction

  function automatic void apply_beat(beat_t b);
    int unsigned nr, nk, nc;
    int unsigned r, c, k;
    longint      acc;
    product_t    p;
    nr = clip_dim(dim_rows);
    nk = clip_dim(dim_inner);
    nc = clip_dim(dim_cols);
    case (b.op)
      OP_LOAD_A: if (b.idx < nr * nk) a_mem[b.idx] = b.val;
      OP_LOAD_B: if (b.idx < nk * nc) b_mem[b.idx] = b.val;
      OP_COMPUTE: begin
        for (r = 0; r < nr; r++) begin
          for (c = 0; c < nc; c++) begin
            acc = 0;
            for (k = 0; k < nk; k++)
              acc += longint'(a_mem[r * nk + k]) * longint'(b_mem[k * nc + c]);
            p.value = acc[RES_W-1:0];
            p.row   = r[IDX_W-1:0];
            p.col   = c[IDX_W-1:0];
            p.last  = (r == nr - 1) && (c == nc - 1);
            expected_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Input driver
  always @(posedge clk or negedge rst_n) begin
    beat_t got;
    beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= OP_LOAD_A;
      in_ch.elem_index <= '0;
      in_ch.element_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        got.op  = in_ch.opcode;
        got.idx = in_ch.elem_index;
        got.val = in_ch.element_value;
        apply_beat(got);
        beats_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= nxt.op;
          in_ch.elem_index <= nxt.idx;
          in_ch.element_value <= nxt.val;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk or negedge rst_n) begin
    product_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_products.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got value %0d row %0d col %0d",
                   $time, out_ch.result_value, out_ch.out_row, out_ch.out_col);
        end else begin
          want = expected_products.pop_front();
          if (out_ch.result_value !== want.value) begin
            mismatches++;
            $display("%0t: result_value mismatch at (%0d,%0d), expected %0d, got %0d",
                     $time, want.row, want.col, want.value, out_ch.result_value);
          end
          if (out_ch.out_row !== want.row) begin
            mismatches++;
            $display("%0t: out_row mismatch, expected %0d, got %0d",
                     $time, want.row, out_ch.out_row);
          end
          if (out_ch.out_col !== want.col) begin
            mismatches++;
            $display("%0t: out_col mismatch, expected %0d, got %0d",
                     $time, want.col, out_ch.out_col);
          end
          if (out_ch.is_last !== want.last) begin
            mismatches++;
            $display("%0t: is_last mismatch at (%0d,%0d), expected %0b, got %0b",
                     $time, want.row, want.col, want.last, out_ch.is_last);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [ELEM_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  task automatic push_beat(logic [1:0] op, logic [ADDR_W-1:0] idx,
                           logic signed [ELEM_WIDTH-1:0] val);
    beat_t b;
    int unsigned nr, nk, nc;
    nr = clip_dim(dim_rows);
    nk = clip_dim(dim_inner);
    nc = clip_dim(dim_cols);
    b.op  = op;
    b.idx = idx;
    b.val = val;
    pending_beats.push_back(b);
    beats_queued++;
    if (op == OP_LOAD_A && idx < nr * nk) gen_a_ok[idx] = 1'b1;
    if (op == OP_LOAD_B && idx < nk * nc) gen_b_ok[idx] = 1'b1;
  endtask

  // Load every entry the next compute reads that has not been written yet
  task automatic queue_compute();
    int unsigned nr, nk, nc, i;
    nr = clip_dim(dim_rows);
    nk = clip_dim(dim_inner);
    nc = clip_dim(dim_cols);
    for (i = 0; i < nr * nk; i++)
      if (!gen_a_ok[i]) push_beat(OP_LOAD_A, ADDR_W'(i), pick_value());
    for (i = 0; i < nk * nc; i++)
      if (!gen_b_ok[i]) push_beat(OP_LOAD_B, ADDR_W'(i), pick_value());
    push_beat(OP_COMPUTE, ADDR_W'($urandom), ELEM_WIDTH'($urandom));
  endtask

  task automatic wait_idle();
    while (beats_accepted != beats_queued || expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
    wait_idle();
    @(posedge clk);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ROWS;
    cfg_data_i <= r;
    @(posedge clk);
    cfg_index_i <= CFG_INNER;
    cfg_data_i <= k;
    @(posedge clk);
    cfg_index_i <= CFG_COLS;
    cfg_data_i <= c;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    dim_rows = r;
    dim_inner = k;
    dim_cols = c;
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned counted, roll, area_a, area_b;
    area_a = clip_dim(dim_rows) * clip_dim(dim_inner);
    area_b = clip_dim(dim_inner) * clip_dim(dim_cols);
    counted = 0;
    while (counted < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 40 && area_a != 0) begin
        push_beat(OP_LOAD_A, ADDR_W'($urandom_range(0, area_a - 1)), pick_value());
        counted++;
      end else if (roll >= 40 && roll < 80 && area_b != 0) begin
        push_beat(OP_LOAD_B, ADDR_W'($urandom_range(0, area_b - 1)), pick_value());
        counted++;
      end else if (roll >= 80 && roll < 86) begin
        if ($urandom_range(0, 1) == 0) begin
          if (area_a < DEPTH)
            push_beat(OP_LOAD_A, ADDR_W'($urandom_range(area_a, DEPTH - 1)), pick_value());
        end else if (area_b < DEPTH) begin
          push_beat(OP_LOAD_B, ADDR_W'($urandom_range(area_b, DEPTH - 1)), pick_value());
        end
      end else if (roll >= 86 && roll < 90) begin
        push_beat(OP_UNUSED, ADDR_W'($urandom), pick_value());
      end else if (roll >= 90) begin
        queue_compute();
        counted++;
      end
    end
  endtask

  task automatic run_phase(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c,
                           int unsigned n);
    set_dims(r, k, c);
    queue_random(n);
    queue_compute();
  endtask

  initial begin
    int unsigned i;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_ROWS;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 68;

    // 2x2x2 with extreme elements, dropped loads and the unused opcode
    set_dims(4'd2, 4'd2, 4'd2);
    push_beat(OP_LOAD_A, 6'd0, 16'sh8000);
    push_beat(OP_LOAD_A, 6'd1, 16'sh7fff);
    push_beat(OP_LOAD_A, 6'd2, -16'sd1);
    push_beat(OP_LOAD_A, 6'd3, 16'sd1);
    push_beat(OP_LOAD_B, 6'd0, 16'sh8000);
    push_beat(OP_LOAD_B, 6'd1, 16'sh8000);
    push_beat(OP_LOAD_B, 6'd2, 16'sh7fff);
    push_beat(OP_LOAD_B, 6'd3, -16'sd1);
    push_beat(OP_LOAD_A, 6'd63, 16'sh7fff);
    push_beat(OP_LOAD_B, 6'd4, 16'sh7fff);
    push_beat(OP_UNUSED, 6'd63, -16'sd1);
    push_beat(OP_COMPUTE, 6'd0, 16'sd0);

    // zero rows emits nothing, zero inner dimension emits zeros
    set_dims(4'd0, 4'd2, 4'd2);
    push_beat(OP_COMPUTE, 6'd63, 16'sd0);
    set_dims(4'd3, 4'd0, 4'd2);
    push_beat(OP_COMPUTE, 6'd0, -16'sd1);

    run_phase(4'd1, 4'd1, 4'd1, 8);
    run_phase(4'd3, 4'd2, 4'd4, 8);
    run_phase(4'd2, 4'd5, 4'd3, 8);

    send_idle_pct = 68;
    recv_idle_pct = 35;
    run_phase(4'd8, 4'd1, 4'd8, 8);
    run_phase(4'd1, 4'd8, 4'd1, 8);
    run_phase(4'd4, 4'd3, 4'd0, 8);
    run_phase(4'd9, 4'd2, 4'd12, 8);

    // full-size products at both ends of the range while results are held off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_dims(4'd15, 4'd15, 4'd15);
    hold_toggle <= ~hold_toggle;
    for (i = 0; i < DEPTH; i++) push_beat(OP_LOAD_A, ADDR_W'(i), 16'sh8000);
    for (i = 0; i < DEPTH; i++) push_beat(OP_LOAD_B, ADDR_W'(i), 16'sh8000);
    push_beat(OP_COMPUTE, 6'd0, 16'sd0);
    for (i = 0; i < MAX_DIM; i++) push_beat(OP_LOAD_B, ADDR_W'(i * MAX_DIM), 16'sh7fff);
    push_beat(OP_COMPUTE, 6'd0, 16'sd0);

    run_phase(4'd5, 4'd4, 4'd3, 8);
    run_phase(4'd2, 4'd8, 4'd2, 8);

    wait_idle();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
